// File: sv/lics_pkg.sv
// ----------------------------------------------------------------------------
// lics_pkg
// Shared types, constants and elaboration-time table builders for the
// Laplace inverse-CDF sampler.
// ----------------------------------------------------------------------------
package lics_pkg;

  // default log table index width
  localparam int unsigned LOG_TABLE_BITS_DEF = 8;

  // long division of the series argument: steps per stage and stage count
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_STAGES = 64 / DIV_STEPS;

  // sqrt(1/2) in Q0.64, truncated
  localparam logic [63:0] RSQRT2_Q64 = 64'hB504_F333_F9DE_6484;

  // output saturation limits, Q23.16
  localparam logic [39:0] OUT_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] OUT_MIN = 40'h80_0000_0000;

  // four 32x32 partial products of a 64x64 product
  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  // per-request side information carried down the pipeline
  typedef struct packed {
    logic [31:0] loc;
    logic [31:0] scale;
    logic        last;
    logic        zs;
    logic        cz;
    logic        upper;
  } side_t;

  // partial products of a * b
  function automatic pp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    pp_t pp;
    pp.p00 = {32'b0, a[31:0]} * {32'b0, b[31:0]};
    pp.p01 = {32'b0, a[31:0]} * {32'b0, b[63:32]};
    pp.p10 = {32'b0, a[63:32]} * {32'b0, b[31:0]};
    pp.p11 = {32'b0, a[63:32]} * {32'b0, b[63:32]};
    return pp;
  endfunction

  // upper 64 bits of the product from its partials
  function automatic logic [63:0] mul_hi_comb(input pp_t pp);
    logic [63:0] mid;
    mid = {32'b0, pp.p00[63:32]} + {32'b0, pp.p01[31:0]} + {32'b0, pp.p10[31:0]};
    return pp.p11 + {32'b0, pp.p01[63:32]} + {32'b0, pp.p10[63:32]} + {32'b0, mid[63:32]};
  endfunction

  // upper 64 bits of a product, for table building only
  function automatic logic [63:0] mul_hi_const(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'b0, a} * {64'b0, b};
    return prod[127:64];
  endfunction

  // restoring integer division, for table building only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // num / den as a Q0.64 fraction, zero unless num < den
  function automatic logic [63:0] frac_q64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = {1'b0, num};
    q = '0;
    if (den == '0 || num >= den) begin
      return '0;
    end
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln((den + num) / (den - num)) by the atanh series, Q0.64
  function automatic logic [63:0] log_ratio(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] k;
    y   = frac_q64(num, den);
    y2  = mul_hi_const(y, y);
    p   = y;
    acc = '0;
    k   = 64'd1;
    while (p != '0 && k < 64'd256) begin
      acc = acc + udiv64(p, k);
      p   = mul_hi_const(p, y2);
      k   = k + 64'd2;
    end
    return {acc[62:0], 1'b0};
  endfunction

  // table entry ln(1 + i / 2^bits), Q0.64
  function automatic logic [63:0] log_tab_entry(input int unsigned i, input int unsigned bits);
    logic [63:0] den;
    den = (64'd1 << (bits + 1)) + 64'(i);
    return log_ratio(64'(i), den);
  endfunction

  // ln2 in Q0.64 and in Q5.59
  localparam logic [63:0] LN2_Q64 = log_ratio(64'd1, 64'd3);
  localparam logic [63:0] LN2_S5  = LN2_Q64 >> 5;

endpackage

// File: sv/laplace_inverse_cdf_sampler.sv
// ----------------------------------------------------------------------------
// laplace_inverse_cdf_sampler
// Laplace variate from a uniform code, location and scale, by inverse CDF.
// ----------------------------------------------------------------------------
// One request in and one sample out per clock while out_ready_i is high.
// The pipeline depth is set by the ln(1 + t) power series of NUM_TERMS =
// ceil(64 / LOG_TABLE_BITS) - 1 terms: each term takes a 64-bit product
// split into 32-bit partials and a four-digit division by the term index,
// four stages per term, after an eight-stage long division that forms t.
// Every stage holds a valid bit and advances on its own, so bubbles close
// up while the output waits.
// Zero scale returns the location; code zero with nonzero scale returns the
// positive limit.
module laplace_inverse_cdf_sampler #(
  parameter int unsigned LOG_TABLE_BITS = lics_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        uniform_code_i,
  input  logic signed [31:0] location_q_i,
  input  logic [31:0]        scale_q_i,
  input  logic               last_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [39:0] sample_out_o,
  output logic               last_out_o
);

  localparam int unsigned TAB_SIZE   = 2 ** LOG_TABLE_BITS;
  localparam int unsigned DW         = LOG_TABLE_BITS + 1;
  localparam int unsigned REM_W      = 31 - LOG_TABLE_BITS;
  localparam int unsigned NUM_TERMS  = (64 + LOG_TABLE_BITS - 1) / LOG_TABLE_BITS - 1;
  localparam int unsigned DIV_STAGES = lics_pkg::DIV_STAGES;
  localparam int unsigned SER_STAGES = 4 * NUM_TERMS;
  localparam int unsigned S_SER0     = 4 + DIV_STAGES;
  localparam int unsigned S_FIN0     = S_SER0 + SER_STAGES;
  localparam int unsigned NUM_STAGES = S_FIN0 + 7;

  // pipeline control
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;

  lics_pkg::side_t side_q [NUM_STAGES];
  logic [4:0]      e_q    [1:S_FIN0-1];
  logic [63:0]     tab_q  [3:S_FIN0-1];

  // front end
  logic [31:0]           m0_q;
  logic [31:0]           m1_q;
  logic [LOG_TABLE_BITS-1:0] idx_q;
  logic [REM_W-1:0]      rem_q;
  logic [31:0]           m0_d;
  logic [4:0]            lead_e;
  logic [31:0]           norm;
  lics_pkg::side_t       side_in;

  // long division of the series argument
  logic [63:0]   dn_q [DIV_STAGES+1];
  logic [63:0]   dq_q [DIV_STAGES+1];
  logic [DW-1:0] dr_q [DIV_STAGES+1];
  logic [DW-1:0] dd_q [DIV_STAGES+1];

  // series of ln(1 + t)
  logic [63:0]   ser_p_q   [SER_STAGES];
  logic [63:0]   ser_t_q   [SER_STAGES];
  logic [63:0]   ser_acc_q [SER_STAGES];
  logic [63:0]   ser_q_q   [SER_STAGES];
  logic [63:0]   ser_pn_q  [SER_STAGES];
  logic [3:0]    ser_r_q   [SER_STAGES];
  lics_pkg::pp_t ser_pp_q  [NUM_TERMS];

  // back end
  logic [63:0]        g_q;
  logic [63:0]        whole_q;
  logic [63:0]        d59_q;
  lics_pkg::pp_t      fpp_q;
  logic [63:0]        t59_q;
  logic [63:0]        hi_q;
  logic [63:0]        lo_q;
  logic [36:0]        delta_q;
  logic signed [39:0] out_q;
  logic [63:0]        gs5;
  logic [63:0]        mid;
  logic [63:0]        rnd;
  logic [40:0]        loc41;
  logic [40:0]        res41;
  logic [39:0]        out_d;

  // log table, built at elaboration
  logic [63:0] log_tab [TAB_SIZE];
  for (genvar gi = 0; gi < TAB_SIZE; gi++) begin : g_tab
    localparam logic [63:0] Entry = lics_pkg::log_tab_entry(gi, LOG_TABLE_BITS);
    assign log_tab[gi] = Entry;
  end

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || out_ready_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // input decode: fold upper half onto the lower one
  always_comb begin
    side_in.loc   = location_q_i;
    side_in.scale = scale_q_i;
    side_in.last  = last_in_i;
    side_in.zs    = (scale_q_i == '0);
    side_in.cz    = (uniform_code_i == '0);
    side_in.upper = uniform_code_i[31];
    m0_d = uniform_code_i[31] ? (32'd0 - uniform_code_i) : uniform_code_i;
  end

  // leading one of m
  always_comb begin
    lead_e = '0;
    for (int b = 0; b < 32; b++) begin
      if (m0_q[b]) begin
        lead_e = 5'(b);
      end
    end
  end

  // normalize m so that its leading one sits at bit 31
  assign norm = m1_q << ~e_q[1];

  // side, exponent and table value travel with the request
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_in;
      m0_q      <= m0_d;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        side_q[i] <= side_q[i-1];
      end
    end
    if (en[1]) begin
      m1_q   <= m0_q;
      e_q[1] <= lead_e;
    end
    for (int i = 2; i < S_FIN0; i++) begin
      if (en[i]) begin
        e_q[i] <= e_q[i-1];
      end
    end
    if (en[2]) begin
      idx_q <= norm[30 -: LOG_TABLE_BITS];
      rem_q <= norm[REM_W-1:0];
    end
    if (en[3]) begin
      tab_q[3] <= log_tab[idx_q];
      dn_q[0]  <= {rem_q, {(33 + LOG_TABLE_BITS){1'b0}}};
      dq_q[0]  <= '0;
      dr_q[0]  <= '0;
      dd_q[0]  <= {1'b1, idx_q};
    end
    for (int i = 4; i < S_FIN0; i++) begin
      if (en[i]) begin
        tab_q[i] <= tab_q[i-1];
      end
    end
  end

  // long division t = rem * 2^(33+B) / (2^B + idx), DIV_STEPS bits per stage
  for (genvar gj = 0; gj < DIV_STAGES; gj++) begin : g_div
    logic [63:0]   n_d;
    logic [63:0]   q_d;
    logic [DW-1:0] r_d;

    always_comb begin : p_steps
      logic [DW:0] rs;
      rs  = '0;
      n_d = dn_q[gj];
      q_d = dq_q[gj];
      r_d = dr_q[gj];
      for (int st = 0; st < lics_pkg::DIV_STEPS; st++) begin
        rs  = {r_d, n_d[63]};
        n_d = {n_d[62:0], 1'b0};
        if (rs >= {1'b0, dd_q[gj]}) begin
          rs  = rs - {1'b0, dd_q[gj]};
          q_d = {q_d[62:0], 1'b1};
        end else begin
          q_d = {q_d[62:0], 1'b0};
        end
        r_d = rs[DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[4+gj]) begin
        dn_q[gj+1] <= n_d;
        dq_q[gj+1] <= q_d;
        dr_q[gj+1] <= r_d;
        dd_q[gj+1] <= dd_q[gj];
      end
    end
  end

  // series terms: partial products, next power, quotient by k, accumulate
  for (genvar gs = 0; gs < SER_STAGES; gs++) begin : g_ser
    localparam int unsigned Unit    = gs / 4;
    localparam int unsigned Col     = gs % 4;
    localparam int unsigned K       = Unit + 1;
    localparam int unsigned Recip   = ((1 << 24) + K - 1) / K;
    localparam int unsigned DigitLo = 16 * (3 - Col);

    logic [63:0] p_src;
    logic [63:0] t_src;
    logic [63:0] acc_src;
    logic [63:0] q_src;
    logic [63:0] pn_src;
    logic [3:0]  r_src;
    logic [19:0] v;
    logic [44:0] prod;
    logic [15:0] qd;
    logic [19:0] qk;
    logic [63:0] q_new;
    logic [63:0] acc_new;
    logic [63:0] pn_new;

    if (Col == 0 && Unit == 0) begin : g_first
      assign p_src   = dq_q[DIV_STAGES];
      assign t_src   = dq_q[DIV_STAGES];
      assign acc_src = '0;
    end else if (Col == 0) begin : g_head
      assign p_src   = ser_pn_q[gs-1];
      assign t_src   = ser_t_q[gs-1];
      assign acc_src = ser_acc_q[gs-1];
    end else begin : g_body
      assign p_src   = ser_p_q[gs-1];
      assign t_src   = ser_t_q[gs-1];
      assign acc_src = ser_acc_q[gs-1];
    end

    if (Col == 0) begin : g_clr
      assign q_src  = '0;
      assign r_src  = '0;
      assign pn_src = p_src;
    end else begin : g_pass
      assign q_src  = ser_q_q[gs-1];
      assign r_src  = ser_r_q[gs-1];
      assign pn_src = ser_pn_q[gs-1];
    end

    // one 16-bit digit of p / k by reciprocal
    always_comb begin
      v     = {r_src, p_src[DigitLo +: 16]};
      prod  = 45'(v) * 45'(Recip);
      qd    = prod[39:24];
      qk    = 20'(qd) * 20'(K);
      q_new = {q_src[47:0], qd};
    end

    if (Col == 3) begin : g_acc
      if (K % 2 == 1) begin : g_add
        assign acc_new = acc_src + q_new;
      end else begin : g_sub
        assign acc_new = acc_src - q_new;
      end
    end else begin : g_hold
      assign acc_new = acc_src;
    end

    if (Col == 1) begin : g_pow
      assign pn_new = lics_pkg::mul_hi_comb(ser_pp_q[Unit]);
    end else begin : g_keep
      assign pn_new = pn_src;
    end

    always_ff @(posedge clk_i) begin
      if (en[S_SER0+gs]) begin
        ser_p_q[gs]   <= p_src;
        ser_t_q[gs]   <= t_src;
        ser_acc_q[gs] <= acc_new;
        ser_q_q[gs]   <= q_new;
        ser_r_q[gs]   <= 4'(v - qk);
        ser_pn_q[gs]  <= pn_new;
      end
    end

    if (Col == 0) begin : g_pp
      always_ff @(posedge clk_i) begin
        if (en[S_SER0+gs]) begin
          ser_pp_q[Unit] <= lics_pkg::mul_parts(p_src, t_src);
        end
      end
    end
  end

  // back end arithmetic
  always_comb begin
    gs5   = {5'b0, g_q[63:5]};
    mid   = hi_q + {32'b0, lo_q[63:32]};
    rnd   = mid + (64'd1 << 26);
    loc41 = {{9{side_q[S_FIN0+5].loc[31]}}, side_q[S_FIN0+5].loc};
    res41 = side_q[S_FIN0+5].upper ? loc41 + {4'b0, delta_q} : loc41 - {4'b0, delta_q};
    if (side_q[S_FIN0+5].zs) begin
      out_d = loc41[39:0];
    end else if (side_q[S_FIN0+5].cz) begin
      out_d = lics_pkg::OUT_MAX;
    end else if (res41[40] != res41[39]) begin
      out_d = res41[40] ? lics_pkg::OUT_MIN : lics_pkg::OUT_MAX;
    end else begin
      out_d = res41[39:0];
    end
  end

  // back end registers
  always_ff @(posedge clk_i) begin
    if (en[S_FIN0]) begin
      g_q     <= tab_q[S_FIN0-1] + ser_acc_q[SER_STAGES-1];
      whole_q <= lics_pkg::LN2_S5 * {59'b0, ~e_q[S_FIN0-1]};
    end
    if (en[S_FIN0+1]) begin
      d59_q <= (whole_q > gs5) ? whole_q - gs5 : '0;
    end
    if (en[S_FIN0+2]) begin
      fpp_q <= lics_pkg::mul_parts(lics_pkg::RSQRT2_Q64, d59_q);
    end
    if (en[S_FIN0+3]) begin
      t59_q <= lics_pkg::mul_hi_comb(fpp_q);
    end
    if (en[S_FIN0+4]) begin
      hi_q <= {32'b0, side_q[S_FIN0+3].scale} * {32'b0, t59_q[63:32]};
      lo_q <= {32'b0, side_q[S_FIN0+3].scale} * {32'b0, t59_q[31:0]};
    end
    if (en[S_FIN0+5]) begin
      delta_q <= rnd[63:27];
    end
    if (en[S_FIN0+6]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o  = v_q[NUM_STAGES-1];
  assign sample_out_o = out_q;
  assign last_out_o   = side_q[NUM_STAGES-1].last;

`ifndef SYNTHESIS
  // an empty output stage lets every stage move
  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NUM_STAGES-1] |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  // requests in flight change only by accepted and delivered requests
  a_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> $countones(v_q) == $past($countones(v_q))
      + int'($past(in_valid_i && in_ready_o)) - int'($past(out_valid_o && out_ready_i)))
    else $error("request lost or duplicated in the pipeline");

  // divider partial remainder stays below a normalized divisor
  for (genvar ga = 0; ga <= DIV_STAGES; ga++) begin : g_div_chk
    a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
      v_q[3+ga] |-> dd_q[ga][DW-1] && (dr_q[ga] < dd_q[ga]))
      else $error("divider remainder out of range");
  end
`endif

endmodule
